// ===== rtl/lca_binary_lifting_defines.svh =====
// assertion shorthands for the common ancestor engine
`ifndef LCA_BINARY_LIFTING_DEFINES_SVH
`define LCA_BINARY_LIFTING_DEFINES_SVH

// same-cycle implication, sampled on clk_i and quiet during reset
`define LCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lca_pkg.sv =====
package lca_pkg;

  localparam int FIELD_W = 12;
  localparam int DEPTH_W = 12;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  localparam int NODES_DEF  = 4096;
  localparam int LEVELS_DEF = 12;

  localparam logic KIND_ATTACH = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    DEP_A,
    DEP_B,
    DEP_UP
  } dep_sel_e;

  typedef struct packed {
    logic     clr_we;
    logic     load;
    logic     red_step;
    logic     att_init;
    logic     att_dep;
    logic     att_step;
    logic     att_write;
    logic     ja_mid;
    dep_sel_e dep_sel;
    logic     q_da;
    logic     q_swap;
    logic     q_up;
    logic     q_lift1;
    logic     q_res_a;
    logic     q_lift2;
    logic     q_last;
    logic     out_load;
  } lca_cmd_t;

  typedef struct packed {
    logic kind;
    logic node_zero;
    logic a_eq_b;
  } lca_stat_t;

  // number of compare-subtract steps that fold a field value below nodes
  function automatic int red_steps(int nodes);
    int k;
    k = 0;
    for (int j = 0; j < FIELD_W; j++) begin
      if ((longint'(nodes) << j) < (longint'(1) << FIELD_W)) k = j + 1;
    end
    return k;
  endfunction

  // first subtrahend of the fold: the largest nodes << j that fits the field
  function automatic logic [FIELD_W-1:0] red_top(int nodes);
    int k;
    logic [FIELD_W-1:0] v;
    k = red_steps(nodes);
    v = '0;
    if (k > 0) v = FIELD_W'(longint'(nodes) << (k - 1));
    return v;
  endfunction

endpackage

// ===== rtl/lca_dp.sv =====
module lca_dp #(
  parameter int NODES  = lca_pkg::NODES_DEF,
  parameter int LEVELS = lca_pkg::LEVELS_DEF
) (
  input  logic                           clk_i,
  input  lca_pkg::lca_cmd_t              cmd_i,
  input  logic [$clog2(LEVELS)-1:0]      lvl_i,
  input  logic [$clog2(NODES)-1:0]       clr_addr_i,
  input  logic                           kind_i,
  input  logic [lca_pkg::FIELD_W-1:0]    node_first_i,
  input  logic [lca_pkg::FIELD_W-1:0]    node_second_i,
  output lca_pkg::lca_stat_t             stat_o,
  output logic [lca_pkg::FIELD_W-1:0]    ancestor_o
);
  import lca_pkg::*;

  localparam int NW   = $clog2(NODES);
  localparam int LvlW = $clog2(LEVELS);
  localparam int KW   = (NW > FIELD_W) ? NW : FIELD_W;
  localparam logic [FIELD_W-1:0] RedTop = red_top(NODES);

  typedef logic [LEVELS-1:0][NW-1:0] row_t;

  row_t               jmem [NODES];
  logic [DEPTH_W-1:0] dmem [NODES];

  logic               kind_q;
  logic [KW-1:0]      a_q, b_q;
  logic [FIELD_W-1:0] sub_q;
  logic [DEPTH_W-1:0] da_q, db_q, dnew_q, dep_q;
  logic [NW-1:0]      up_q, mid_q, res_q;
  row_t               row_q, rowa_q, rowb_q;
  logic [FIELD_W-1:0] anc_q;

  logic [NW-1:0]      a_idx, b_idx, sel_a, sel_b, prev_a, att_val;
  logic [NW-1:0]      ja_addr, d_addr, j_waddr, d_waddr;
  logic [LvlW-1:0]    lvl_prev;
  logic               j_we, d_we;
  row_t               j_wdata;
  logic [DEPTH_W-1:0] d_wdata, dnew;

  assign a_idx    = NW'(a_q);
  assign b_idx    = NW'(b_q);
  assign lvl_prev = lvl_i - LvlW'(1);
  assign sel_a    = rowa_q[lvl_i];
  assign sel_b    = rowb_q[lvl_i];
  assign prev_a   = rowa_q[lvl_prev];
  // a node hung under itself reads its own freshly built level
  assign att_val  = (mid_q == a_idx) ? mid_q : prev_a;
  assign ja_addr  = cmd_i.ja_mid ? mid_q : a_idx;
  assign dnew     = (dep_q == DEPTH_MAX) ? dep_q : dep_q + DEPTH_W'(1);

  always_comb begin
    case (cmd_i.dep_sel)
      DEP_A:   d_addr = a_idx;
      DEP_B:   d_addr = b_idx;
      DEP_UP:  d_addr = sel_a;
      default: d_addr = a_idx;
    endcase
  end

  assign j_we    = cmd_i.clr_we | cmd_i.att_write;
  assign j_waddr = cmd_i.clr_we ? clr_addr_i : a_idx;
  assign j_wdata = cmd_i.clr_we ? '0 : row_q;
  assign d_we    = cmd_i.clr_we | cmd_i.att_write;
  assign d_waddr = cmd_i.clr_we ? clr_addr_i : a_idx;
  assign d_wdata = cmd_i.clr_we ? '0 : dnew_q;

  always_ff @(posedge clk_i) begin
    if (j_we) jmem[j_waddr] <= j_wdata;
    rowa_q <= jmem[ja_addr];
    rowb_q <= jmem[b_idx];
  end

  always_ff @(posedge clk_i) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    dep_q <= dmem[d_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      a_q    <= KW'(node_first_i);
      b_q    <= KW'(node_second_i);
      sub_q  <= RedTop;
    end
    // node numbers folded modulo the store size
    if (cmd_i.red_step) begin
      if (a_q >= KW'(sub_q)) a_q <= a_q - KW'(sub_q);
      if (b_q >= KW'(sub_q)) b_q <= b_q - KW'(sub_q);
      sub_q <= sub_q >> 1;
    end
    if (cmd_i.att_init) begin
      row_q[0] <= b_idx;
      mid_q    <= b_idx;
    end
    if (cmd_i.att_dep) dnew_q <= dnew;
    if (cmd_i.att_step) begin
      row_q[lvl_i] <= att_val;
      mid_q        <= att_val;
    end
    if (cmd_i.q_da) da_q <= dep_q;
    if (cmd_i.q_swap) begin
      if (da_q < dep_q) begin
        a_q  <= b_q;
        b_q  <= a_q;
        db_q <= da_q;
      end else begin
        db_q <= dep_q;
      end
    end
    if (cmd_i.q_up) up_q <= sel_a;
    if (cmd_i.q_lift1 && (dep_q >= db_q)) a_q <= KW'(up_q);
    if (cmd_i.q_res_a) res_q <= a_idx;
    if (cmd_i.q_lift2 && (sel_a != sel_b)) begin
      a_q <= KW'(sel_a);
      b_q <= KW'(sel_b);
    end
    if (cmd_i.q_last) res_q <= rowa_q[0];
    if (cmd_i.out_load) anc_q <= FIELD_W'(res_q);
  end

  assign stat_o.kind      = kind_q;
  assign stat_o.node_zero = (a_idx == '0);
  assign stat_o.a_eq_b    = (a_idx == b_idx);
  assign ancestor_o       = anc_q;

endmodule

// ===== rtl/lca_ctrl.sv =====
module lca_ctrl #(
  parameter int NODES  = lca_pkg::NODES_DEF,
  parameter int LEVELS = lca_pkg::LEVELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  lca_pkg::lca_stat_t        stat_i,
  output lca_pkg::lca_cmd_t         cmd_o,
  output logic [$clog2(LEVELS)-1:0] lvl_o,
  output logic [$clog2(NODES)-1:0]  clr_addr_o
);
  import lca_pkg::*;

  localparam int NW       = $clog2(NODES);
  localparam int LvlW     = $clog2(LEVELS);
  localparam int RedSteps = red_steps(NODES);
  localparam int RedW     = (RedSteps > 1) ? $clog2(RedSteps) : 1;
  localparam logic [LvlW-1:0] LastLvl = LvlW'(LEVELS - 1);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_RED    = 5'd2;
  localparam logic [4:0] S_START  = 5'd3;
  localparam logic [4:0] S_A_RD   = 5'd4;
  localparam logic [4:0] S_A_CAP  = 5'd5;
  localparam logic [4:0] S_A_WR   = 5'd6;
  localparam logic [4:0] S_Q_DB   = 5'd7;
  localparam logic [4:0] S_Q_SW   = 5'd8;
  localparam logic [4:0] S_L1_ROW = 5'd9;
  localparam logic [4:0] S_L1_DEP = 5'd10;
  localparam logic [4:0] S_L1_CMP = 5'd11;
  localparam logic [4:0] S_Q_EQ   = 5'd12;
  localparam logic [4:0] S_L2_RD  = 5'd13;
  localparam logic [4:0] S_L2_CMP = 5'd14;
  localparam logic [4:0] S_Q_FIN  = 5'd15;
  localparam logic [4:0] S_Q_LAST = 5'd16;
  localparam logic [4:0] S_Q_OUT  = 5'd17;

  logic [4:0]      state_q, state_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [NW-1:0]   clr_q, clr_d;
  logic [RedW-1:0] red_q, red_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    lvl_d         = lvl_q;
    clr_d         = clr_q;
    red_d         = red_q;
    cmd_o         = '0;
    cmd_o.dep_sel = DEP_A;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_d        = clr_q + NW'(1);
        if (clr_q == NW'(NODES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          red_d      = '0;
          state_d    = (RedSteps > 0) ? S_RED : S_START;
        end
      end
      S_RED: begin
        cmd_o.red_step = 1'b1;
        if (red_q == RedW'(RedSteps - 1)) state_d = S_START;
        else red_d = red_q + RedW'(1);
      end
      S_START: begin
        if (stat_i.kind == KIND_ATTACH) begin
          if (stat_i.node_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.att_init = 1'b1;
            cmd_o.dep_sel  = DEP_B;
            lvl_d          = LvlW'(1);
            state_d        = S_A_RD;
          end
        end else begin
          cmd_o.dep_sel = DEP_A;
          state_d       = S_Q_DB;
        end
      end
      S_A_RD: begin
        cmd_o.ja_mid  = 1'b1;
        // parent depth is on the read port only on the first pass
        cmd_o.att_dep = (lvl_q == LvlW'(1));
        state_d       = S_A_CAP;
      end
      S_A_CAP: begin
        cmd_o.att_step = 1'b1;
        if (lvl_q == LastLvl) begin
          state_d = S_A_WR;
        end else begin
          lvl_d   = lvl_q + LvlW'(1);
          state_d = S_A_RD;
        end
      end
      S_A_WR: begin
        cmd_o.att_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_Q_DB: begin
        cmd_o.q_da    = 1'b1;
        cmd_o.dep_sel = DEP_B;
        state_d       = S_Q_SW;
      end
      S_Q_SW: begin
        cmd_o.q_swap = 1'b1;
        lvl_d        = LastLvl;
        state_d      = S_L1_ROW;
      end
      S_L1_ROW: begin
        state_d = S_L1_DEP;
      end
      S_L1_DEP: begin
        cmd_o.q_up    = 1'b1;
        cmd_o.dep_sel = DEP_UP;
        state_d       = S_L1_CMP;
      end
      S_L1_CMP: begin
        cmd_o.q_lift1 = 1'b1;
        if (lvl_q == '0) begin
          state_d = S_Q_EQ;
        end else begin
          lvl_d   = lvl_q - LvlW'(1);
          state_d = S_L1_ROW;
        end
      end
      S_Q_EQ: begin
        if (stat_i.a_eq_b) begin
          cmd_o.q_res_a = 1'b1;
          state_d       = S_Q_OUT;
        end else begin
          lvl_d   = LastLvl;
          state_d = S_L2_RD;
        end
      end
      S_L2_RD: begin
        state_d = S_L2_CMP;
      end
      S_L2_CMP: begin
        cmd_o.q_lift2 = 1'b1;
        if (lvl_q == '0) begin
          state_d = S_Q_FIN;
        end else begin
          lvl_d   = lvl_q - LvlW'(1);
          state_d = S_L2_RD;
        end
      end
      S_Q_FIN: begin
        state_d = S_Q_LAST;
      end
      S_Q_LAST: begin
        cmd_o.q_last = 1'b1;
        state_d      = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      lvl_q       <= '0;
      clr_q       <= '0;
      red_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      clr_q       <= clr_d;
      red_q       <= red_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign lvl_o       = lvl_q;
  assign clr_addr_o  = clr_q;

endmodule

// ===== rtl/lca_binary_lifting.sv =====
// Lowest common ancestor engine (binary lifting). An attach transaction (kind 0) hangs
// node_first under node_second, parent 0 making a root; parents must come before their
// children. A query transaction (kind 1) returns the deepest shared ancestor of its two
// nodes on ancestor_o, or 0 when they share none; an attach gives no result. Node
// numbers are taken modulo NODES. After reset the depth and jump memories are swept to
// zero, one row per cycle, so no transaction is taken until the sweep is done.
// Items are handled one at a time, and an attach that names node 0 is ignored. Both
// attaches and queries are paced by the chain of dependent reads through the jump
// memory (two read ports) and the depth memory (one read port). A query also waits for
// as long as the previous result still sits unaccepted in the output register. When
// NODES is below 4096 each item first folds its node numbers, one bit per cycle. A
// finished result waits in the output register while the next transaction is taken in.
`include "lca_binary_lifting_defines.svh"

module lca_binary_lifting #(
  parameter int NODES  = lca_pkg::NODES_DEF,
  parameter int LEVELS = lca_pkg::LEVELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [lca_pkg::FIELD_W-1:0] node_first_i,
  input  logic [lca_pkg::FIELD_W-1:0] node_second_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lca_pkg::FIELD_W-1:0] ancestor_o
);
  import lca_pkg::*;

  lca_cmd_t                  cmd;
  lca_stat_t                 stat;
  logic [$clog2(LEVELS)-1:0] lvl;
  logic [$clog2(NODES)-1:0]  clr_addr;

  lca_ctrl #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .lvl_o       (lvl),
    .clr_addr_o  (clr_addr)
  );

  lca_dp #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .lvl_i         (lvl),
    .clr_addr_i    (clr_addr),
    .kind_i        (kind_i),
    .node_first_i  (node_first_i),
    .node_second_i (node_second_i),
    .stat_o        (stat),
    .ancestor_o    (ancestor_o)
  );

  `LCA_ASSERT_IMP(a_no_accept_in_clear, cmd.clr_we, in_stall_o, "transaction taken during clear")
  `LCA_ASSERT_IMP(a_accept_loads, in_valid_i && !in_stall_o, cmd.load, "transaction not loaded")
  `LCA_ASSERT_NXT(a_load_shows, cmd.out_load, out_valid_o, "loaded result not shown")
  `LCA_ASSERT_IMP(a_result_from_query, cmd.out_load, stat.kind == KIND_QUERY, "result for attach")

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  import lca_pkg::*;

  localparam int NODE_CNT     = lca_pkg::NODES_DEF;
  localparam int LEVEL_CNT    = lca_pkg::LEVELS_DEF;
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int DRAIN_CYCLES = 5 * LEVEL_CNT + 40;
  localparam int CHAIN_LEN    = 200;
  localparam int SELF_ROUNDS  = 24;
  localparam int RANDOM_ITEMS = 1170;

  typedef logic [FIELD_W-1:0] node_t;

  // mirror of the depth and ancestor stores, plus the ancestors still owed
  class ancestor_board;
    bit [DEPTH_W-1:0] depth_of [NODE_CNT];
    bit [FIELD_W-1:0] hop [NODE_CNT][LEVEL_CNT];
    node_t            owed_q[$];
    int               mismatches;
    int               attaches;
    int               queries;
    int               compared;

    function void hang_node(int n, int p);
      int d;
      int i;
      if (n == 0) return;
      d = int'(depth_of[p]) + 1;
      if (d > int'(DEPTH_MAX)) d = int'(DEPTH_MAX);
      depth_of[n] = DEPTH_W'(d);
      hop[n][0] = FIELD_W'(p);
      // each level reads the row as already rewritten below it
      for (i = 1; i < LEVEL_CNT; i++) hop[n][i] = hop[hop[n][i-1]][i-1];
    endfunction

    function node_t meet_point(int a, int b);
      int t;
      int up;
      int i;
      if (depth_of[a] < depth_of[b]) begin
        t = a;
        a = b;
        b = t;
      end
      for (i = LEVEL_CNT - 1; i >= 0; i--) begin
        up = int'(hop[a][i]);
        if (depth_of[up] >= depth_of[b]) a = up;
      end
      if (a == b) return node_t'(a);
      for (i = LEVEL_CNT - 1; i >= 0; i--) begin
        if (hop[a][i] != hop[b][i]) begin
          a = int'(hop[a][i]);
          b = int'(hop[b][i]);
        end
      end
      return hop[a][0];
    endfunction

    function void note_input(logic kind, node_t first, node_t second);
      int a;
      int b;
      a = int'(first) % NODE_CNT;
      b = int'(second) % NODE_CNT;
      if (kind == KIND_ATTACH) begin
        attaches++;
        hang_node(a, b);
      end else begin
        queries++;
        owed_q = {owed_q, meet_point(a, b)};
      end
    endfunction

    function void check_result(node_t got);
      node_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected ancestor %0d, none expected", $time, got);
        return;
      end
      want = owed_q.pop_front();
      compared++;
      if (got !== want) begin
        mismatches++;
        $display("%0t: ancestor mismatch: expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic  clk_i         = 1'b0;
  logic  rst_ni        = 1'b0;
  logic  in_valid_i    = 1'b0;
  logic  in_stall_o;
  logic  kind_i        = KIND_ATTACH;
  node_t node_first_i  = '0;
  node_t node_second_i = '0;
  logic  out_valid_o;
  logic  out_stall_i   = 1'b0;
  node_t ancestor_o;

  ancestor_board board = new();
  bit            steady = 1'b0;
  node_t         placed[$];

  lca_binary_lifting dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .node_first_i  (node_first_i),
    .node_second_i (node_second_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ancestor_o    (ancestor_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_idle();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic node_t pick_placed();
    return placed[$urandom_range(0, placed.size() - 1)];
  endfunction

  task automatic send_item(logic kind, node_t first, node_t second);
    int idle;
    idle = pick_idle();
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    node_first_i  <= first;
    node_second_i <= second;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(kind, first, second);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.owed_q.size() > 0);
  endtask

  initial begin : result_side
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) board.check_result(ancestor_o);
      if (hold > 0) begin
        hold--;
      end else begin
        hold = pick_idle();
        out_stall_i <= (hold > 0);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("lca_binary_lifting regression: fail");
    $finish;
  end

  initial begin : stimulus
    int    k;
    int    r;
    int    span;
    node_t cur;
    node_t par;
    node_t prev;
    node_t chain[$];

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner cases on a small hand-built forest
    send_item(KIND_QUERY, 12'd0, 12'd0);
    send_item(KIND_ATTACH, 12'd0, 12'd5);        // sentinel stays untouched
    send_item(KIND_ATTACH, 12'd1, 12'd0);
    send_item(KIND_ATTACH, 12'd2, 12'd1);
    send_item(KIND_ATTACH, 12'd3, 12'd1);
    send_item(KIND_ATTACH, 12'd4, 12'd2);
    send_item(KIND_ATTACH, 12'd4095, 12'd4);
    send_item(KIND_QUERY, 12'd4095, 12'd3);
    send_item(KIND_QUERY, 12'd3, 12'd4095);
    send_item(KIND_QUERY, 12'd4095, 12'd4095);
    send_item(KIND_QUERY, 12'd2, 12'd4);
    send_item(KIND_ATTACH, 12'd100, 12'd2000);   // parent never attached
    send_item(KIND_QUERY, 12'd100, 12'd4);
    send_item(KIND_QUERY, 12'd0, 12'd4095);
    send_item(KIND_QUERY, 12'd3000, 12'd3001);
    send_item(KIND_ATTACH, 12'd2, 12'd3);        // re-attach, child rows go stale
    send_item(KIND_QUERY, 12'd4, 12'd2);
    send_item(KIND_ATTACH, 12'd5, 12'd5);        // hung under itself
    send_item(KIND_QUERY, 12'd5, 12'd1);
    send_item(KIND_ATTACH, 12'hAAA, 12'h555);
    send_item(KIND_ATTACH, 12'h555, 12'd1);
    send_item(KIND_QUERY, 12'hAAA, 12'h555);
    send_item(KIND_QUERY, 12'h555, 12'd4095);
    wait_for_results();

    // one long chain so the upper levels get used
    prev = '0;
    for (k = 0; k < CHAIN_LEN; k++) begin
      cur = node_t'(1 + (k * 1237) % 4095);
      send_item(KIND_ATTACH, cur, prev);
      chain = {chain, cur};
      prev = cur;
      if (k % 64 == 63)
        send_item(KIND_QUERY, chain[$urandom_range(0, k)], chain[$urandom_range(0, k)]);
    end
    send_item(KIND_QUERY, chain[0], chain[CHAIN_LEN - 1]);
    send_item(KIND_QUERY, chain[CHAIN_LEN - 1], chain[CHAIN_LEN - 2]);
    for (k = 0; k < 20; k++)
      send_item(KIND_QUERY, chain[$urandom_range(0, CHAIN_LEN - 1)],
                chain[$urandom_range(0, CHAIN_LEN - 1)]);

    // repeated self attach keeps deepening one node, back to back
    steady = 1'b1;
    for (k = 0; k < SELF_ROUNDS; k++) send_item(KIND_ATTACH, 12'd4000, 12'd4000);
    send_item(KIND_ATTACH, 12'd4001, 12'd4000);
    send_item(KIND_QUERY, 12'd4001, 12'd4000);
    send_item(KIND_QUERY, 12'd4001, chain[10]);
    send_item(KIND_QUERY, 12'd4000, 12'd4000);
    steady = 1'b0;

    // random forests, mostly well formed, some noise
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      steady = (k >= 700 && k < 850);
      r = $urandom_range(0, 99);
      if (r < 45 || placed.size() < 2) begin
        cur = node_t'($urandom_range(1, NODE_CNT - 1));
        if (placed.size() == 0 || $urandom_range(0, 4) == 0) begin
          par = '0;
        end else if ($urandom_range(0, 1) == 1) begin
          // favor recent nodes so the trees grow deep
          span = (placed.size() < 4) ? placed.size() - 1 : 3;
          par = placed[placed.size() - 1 - $urandom_range(0, span)];
        end else begin
          par = pick_placed();
        end
        send_item(KIND_ATTACH, cur, par);
        placed = {placed, cur};
      end else if (r < 85) begin
        send_item(KIND_QUERY, pick_placed(), pick_placed());
      end else begin
        case ($urandom_range(0, 5))
          0: send_item(KIND_ATTACH, 12'd0, node_t'($urandom_range(0, NODE_CNT - 1)));
          1: send_item(KIND_ATTACH, node_t'($urandom_range(1, NODE_CNT - 1)),
                       node_t'($urandom_range(0, NODE_CNT - 1)));
          2: begin
            cur = pick_placed();
            send_item(KIND_ATTACH, cur, cur);
          end
          3: send_item(KIND_ATTACH, pick_placed(), pick_placed());
          4: send_item(KIND_QUERY, node_t'($urandom_range(0, NODE_CNT - 1)),
                       node_t'($urandom_range(0, NODE_CNT - 1)));
          default: begin
            cur = pick_placed();
            send_item(KIND_QUERY, cur, ($urandom_range(0, 1) == 1) ? cur : node_t'(0));
          end
        endcase
      end
    end
    steady = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("exercised %0d attach and %0d query transactions, %0d ancestors compared",
             board.attaches, board.queries, board.compared);
    $display("trees: hand-built corners, a %0d-deep chain, repeated self attach, random forests",
             CHAIN_LEN);
    if (board.mismatches == 0 && board.owed_q.size() == 0) begin
      $display("lca_binary_lifting regression: pass");
    end else begin
      $display("%0d mismatches, %0d ancestors never delivered",
               board.mismatches, board.owed_q.size());
      $display("lca_binary_lifting regression: fail");
    end
    $finish;
  end

endmodule

// ===== lca_binary_lifting.f =====
+incdir+rtl
rtl/lca_pkg.sv
rtl/lca_dp.sv
rtl/lca_ctrl.sv
rtl/lca_binary_lifting.sv
sim/tb_top.sv
